@@ design/cluster_centroid_accumulator_top_macros.svh @@
// Assertion macros shared by the centroid accumulator RTL.
// Needs a clock and an active-low reset passed in by the caller.
`ifndef CLUSTER_CENTROID_ACCUMULATOR_TOP_MACROS_SVH
`define CLUSTER_CENTROID_ACCUMULATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CCA_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CCA_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ccacc_pkg.sv @@
// Shared types and constants for the centroid accumulator.
// No dependencies; imported by the top level and the divider.
`default_nettype none

package ccacc_pkg;

    localparam int NUM_CLUSTERS = 256;
    localparam int MAX_DIM      = 1024;

    localparam int LABEL_W   = 8;
    localparam int INDEX_W   = 10;
    localparam int SAMPLE_W  = 16;
    localparam int COUNT_W   = 16;
    localparam int SUM_W     = 32;
    localparam int MEAN_W    = 24;
    localparam int FRAC_SHIFT = 8;

    localparam int DIVIDEND_W = SUM_W + FRAC_SHIFT;
    localparam int DIV_STEP_W = $clog2(DIVIDEND_W);

    localparam int CNT_AW    = $clog2(NUM_CLUSTERS);
    localparam int SUM_DEPTH = NUM_CLUSTERS * MAX_DIM;
    localparam int SUM_AW    = $clog2(SUM_DEPTH);

    localparam int S_TDATA_W = ((LABEL_W + INDEX_W + SAMPLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((COUNT_W + MEAN_W + 7) / 8) * 8;

    // s_tdata field offsets
    localparam int S_LABEL_LSB = 0;
    localparam int S_INDEX_LSB = S_LABEL_LSB + LABEL_W;
    localparam int S_VALUE_LSB = S_INDEX_LSB + INDEX_W;

    typedef enum logic {
        OP_ACCUMULATE = 1'b0,
        OP_QUERY      = 1'b1
    } ccacc_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_RESP
    } ccacc_state_t;

endpackage

`default_nettype wire

@@ design/ccacc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ccacc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ design/ccacc_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on ccacc_pkg and the assertion macro header.
`default_nettype none
`include "cluster_centroid_accumulator_top_macros.svh"

module ccacc_div
    import ccacc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [COUNT_W-1:0]    divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [COUNT_W-1:0]    divisor_reg;
    logic [COUNT_W-1:0]    rem_reg;
    logic [DIVIDEND_W-1:0] dq_reg;  // dividend bits shift out, quotient bits shift in

    logic [COUNT_W:0]      trial;
    logic                  fits;
    logic [COUNT_W:0]      diff;

    assign trial = {rem_reg, dq_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};
    assign diff  = trial - {1'b0, divisor_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
        end else if (busy_reg && step_reg == '0) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            step_reg    <= DIV_STEP_W'(DIVIDEND_W - 1);
            divisor_reg <= divisor;
            rem_reg     <= '0;
            dq_reg      <= dividend;
        end else if (busy_reg) begin
            step_reg <= step_reg - DIV_STEP_W'(1);
            rem_reg  <= fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            dq_reg   <= {dq_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

    `CCA_ASSERT_IMP(a_div_start_idle, aclk, aresetn, start, !busy_reg, "divider restarted while busy")
    `CCA_ASSERT_IMP(a_div_done_idle, aclk, aresetn, done_reg, !busy_reg, "done raised while still busy")
    `CCA_ASSERT_IMP(a_div_nonzero, aclk, aresetn, busy_reg, divisor_reg != '0, "divide by zero")

endmodule

`default_nettype wire

@@ design/cluster_centroid_accumulator_top.sv @@
// Top level of the k-means centroid accumulator: sequencer, seen flags, result register.
// Depends on ccacc_pkg, ccacc_ram, ccacc_div and the assertion macro header.
//
//  channel | dir | tdata (low bit first)                         | tuser
//  --------+-----+-----------------------------------------------+--------------
//  s_      | in  | label[7:0], index[17:8], sample[33:18], pad 0 | opcode [0]
//  m_      | out | member_count[15:0], mean_value[39:16]          | cluster_valid
//
// Steps: an accumulate reads the RAMs, then read-modify-writes sum and count; a query
//   also runs the bit-serial divider (40 quotient bits, then a done strobe); a query
//   of an unseen cluster skips the divider.
// s_tready is high only while the sequencer is idle; a query waits in its result step
//   while m_ still holds an unaccepted transfer, accumulates are not held by m_.
// Reset clears the seen flags, the first-sample flag and the handshake state.
//   Sum and count RAMs are not cleared.
`default_nettype none
`include "cluster_centroid_accumulator_top_macros.svh"

module cluster_centroid_accumulator_top
    import ccacc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // cluster_label, element_index, sample_value
    input  wire logic [0:0]           s_tuser,   // opcode
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // member_count, mean_value
    output logic [0:0]                m_tuser    // cluster_valid
);

    ccacc_state_t state_reg, state_next;

    // captured transfer
    ccacc_op_t            op_reg;
    logic [LABEL_W-1:0]   label_reg;
    logic [INDEX_W-1:0]   idx_reg;
    logic [SAMPLE_W-1:0]  val_reg;

    logic                 first_reg, first_next;   // current sample is its cluster's first
    logic                 seen_reg [NUM_CLUSTERS];
    logic                 seen_rd_reg;             // seen flag of the captured label

    // pending result
    logic                 res_valid_reg;
    logic [COUNT_W-1:0]   res_count_reg;
    logic [MEAN_W-1:0]    res_mean_reg;

    // output register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [COUNT_W-1:0]   m_count_reg;
    logic [MEAN_W-1:0]    m_mean_reg;
    logic                 m_valid_flag_reg;

    // decoded input
    logic [LABEL_W-1:0]   s_label;
    logic [INDEX_W-1:0]   s_index;
    logic                 s_accept;

    // RAM ports
    logic [SUM_W-1:0]     sum_rd;
    logic [COUNT_W-1:0]   cnt_rd;
    logic                 sum_we, cnt_we;
    logic [SUM_W-1:0]     sum_wdata;
    logic [COUNT_W-1:0]   cnt_wdata;
    logic [SUM_AW-1:0]    sum_rd_addr, sum_wr_addr;

    // execute-cycle datapath
    logic [CNT_AW-1:0]    lab_addr;
    logic                 in_range;
    logic                 is_start;
    logic                 seen_cur;
    logic                 first_eff;
    logic                 seen_eff;
    logic [SUM_W:0]       sum_add;
    logic                 query_ok;

    // sequencer controls
    logic                 exec_acc, exec_qry;
    logic                 div_start, div_done;
    logic                 out_load;
    logic [DIVIDEND_W-1:0] div_quot;

    assign s_label  = s_tdata[S_LABEL_LSB +: LABEL_W];
    assign s_index  = s_tdata[S_INDEX_LSB +: INDEX_W];
    assign s_accept = s_tvalid && s_tready;

    assign sum_rd_addr = SUM_AW'(s_label) * SUM_AW'(MAX_DIM) + SUM_AW'(s_index);
    assign sum_wr_addr = SUM_AW'(label_reg) * SUM_AW'(MAX_DIM) + SUM_AW'(idx_reg);

    ccacc_ram #(
        .WIDTH (SUM_W),
        .DEPTH (SUM_DEPTH)
    ) u_sum_ram (
        .aclk    (aclk),
        .wr_en   (sum_we),
        .wr_addr (sum_wr_addr),
        .wr_data (sum_wdata),
        .rd_en   (s_accept),
        .rd_addr (sum_rd_addr),
        .rd_data (sum_rd)
    );

    ccacc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_CLUSTERS)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (cnt_we),
        .wr_addr (lab_addr),
        .wr_data (cnt_wdata),
        .rd_en   (s_accept),
        .rd_addr (CNT_AW'(s_label)),
        .rd_data (cnt_rd)
    );

    ccacc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({sum_rd, FRAC_SHIFT'(0)}),
        .divisor  (cnt_rd),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Execute cycle: RAM data for the captured transfer is valid here.
    assign lab_addr  = CNT_AW'(label_reg);
    assign in_range  = (32'(label_reg) < NUM_CLUSTERS) && (32'(idx_reg) < MAX_DIM);
    assign is_start  = (idx_reg == '0);
    assign seen_cur  = seen_rd_reg;
    // element zero opens a new sample; it is the first one if the cluster was unseen
    assign first_eff = is_start ? !seen_cur : first_reg;
    assign seen_eff  = seen_cur || is_start;
    assign sum_add   = {1'b0, sum_rd} + (SUM_W + 1)'(val_reg);
    assign query_ok  = in_range && seen_cur && (cnt_rd != '0);

    assign exec_acc = (state_reg == ST_EXEC) && (op_reg == OP_ACCUMULATE);
    assign exec_qry = (state_reg == ST_EXEC) && (op_reg == OP_QUERY);

    assign cnt_we    = exec_acc && in_range && is_start;
    assign cnt_wdata = !seen_cur        ? COUNT_W'(1) :
                       (cnt_rd == '1)   ? cnt_rd      : cnt_rd + COUNT_W'(1);

    assign sum_we    = exec_acc && in_range && seen_eff;
    assign sum_wdata = first_eff  ? SUM_W'(val_reg) :
                       sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

    assign first_next = cnt_we ? !seen_cur : first_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (op_reg == OP_ACCUMULATE) begin
                    state_next = ST_IDLE;
                end else if (query_ok) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_EXEC: begin
                div_start = exec_qry && query_ok;
            end
            ST_DIV: begin
            end
            ST_RESP: begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            first_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_CLUSTERS; i++) begin
                seen_reg[i] <= 1'b0;
            end
        end else begin
            state_reg    <= state_next;
            first_reg    <= first_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cnt_we) begin
                seen_reg[lab_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg      <= ccacc_op_t'(s_tuser[0]);
            label_reg   <= s_label;
            idx_reg     <= s_index;
            val_reg     <= s_tdata[S_VALUE_LSB +: SAMPLE_W];
            seen_rd_reg <= seen_reg[CNT_AW'(s_label)];
        end
        if (exec_qry) begin
            res_valid_reg <= query_ok;
            res_count_reg <= query_ok ? cnt_rd : '0;
            res_mean_reg  <= '0;
        end
        if (div_done) begin
            res_mean_reg <= (div_quot[DIVIDEND_W-1:MEAN_W] != '0) ? '1
                                                                  : div_quot[MEAN_W-1:0];
        end
        if (out_load) begin
            m_valid_flag_reg <= res_valid_reg;
            m_count_reg      <= res_count_reg;
            m_mean_reg       <= res_mean_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({m_mean_reg, m_count_reg});
    assign m_tuser  = m_valid_flag_reg;

    `CCA_ASSERT_NXT(a_accept_exec, aclk, aresetn, s_accept, state_reg == ST_EXEC, "accepted transfer not executed")
    `CCA_ASSERT_IMP(a_load_free, aclk, aresetn, out_load, !m_tvalid_reg || m_tready, "result overwrote pending output")
    `CCA_ASSERT_IMP(a_done_in_div, aclk, aresetn, div_done, state_reg == ST_DIV, "divider finished outside divide state")
    `CCA_ASSERT_IMP(a_invalid_zero, aclk, aresetn, m_tvalid_reg && !m_tuser[0], m_tdata == '0, "invalid result carries nonzero data")

endmodule

`default_nettype wire

@@ tb/tb_cluster_centroid_accumulator_top.sv @@
// Self-checking testbench for cluster_centroid_accumulator_top: directed table, then
// random sample streams and queries checked against a local predictor.
// Depends on ccacc_pkg and the RTL of the block; reads no files.
module tb_cluster_centroid_accumulator_top;
    import ccacc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One centroid answer as it travels on the result stream.
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
        logic [MEAN_W-1:0]  mean;
    } centroid_t;

    // Directed row: the transfer to send, plus an answer typed in where it is obvious.
    typedef struct packed {
        ccacc_op_t           op;
        logic [LABEL_W-1:0]  label;
        logic [INDEX_W-1:0]  idx;
        logic [SAMPLE_W-1:0] val;
        logic                typed;
        centroid_t           want;
    } dir_row_t;

    localparam centroid_t NO_CLUSTER = '{1'b0, 16'd0, 24'd0};
    localparam int        N_DIRECTED = 25;
    localparam int        RANDOM_ITEMS = 600;
    localparam int        DRAIN_CYCLES = 64;

    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        // nothing seen after reset, lowest and highest label and index
        '{OP_QUERY,      8'd0,   10'd0,    16'h0000, 1'b1, NO_CLUSTER},
        '{OP_QUERY,      8'd255, 10'd1023, 16'hFFFF, 1'b1, NO_CLUSTER},
        // first sample of cluster 7: written, count 1
        '{OP_ACCUMULATE, 8'd7,   10'd0,    16'hFFFF, 1'b0, NO_CLUSTER},
        '{OP_ACCUMULATE, 8'd7,   10'd1,    16'h0000, 1'b0, NO_CLUSTER},
        '{OP_ACCUMULATE, 8'd7,   10'd2,    16'h0100, 1'b0, NO_CLUSTER},
        '{OP_QUERY,      8'd7,   10'd0,    16'h0000, 1'b1, '{1'b1, 16'd1, 24'hFFFF00}},
        '{OP_QUERY,      8'd7,   10'd1,    16'h0000, 1'b1, '{1'b1, 16'd1, 24'h000000}},
        '{OP_QUERY,      8'd7,   10'd2,    16'h0000, 1'b1, '{1'b1, 16'd1, 24'h010000}},
        // second sample adds in and bumps the count
        '{OP_ACCUMULATE, 8'd7,   10'd0,    16'h0200, 1'b0, NO_CLUSTER},
        '{OP_ACCUMULATE, 8'd7,   10'd1,    16'hFFFF, 1'b0, NO_CLUSTER},
        '{OP_QUERY,      8'd7,   10'd0,    16'h0000, 1'b0, NO_CLUSTER},
        // element of an unseen cluster with no start: dropped
        '{OP_ACCUMULATE, 8'd9,   10'd5,    16'h1234, 1'b0, NO_CLUSTER},
        '{OP_QUERY,      8'd9,   10'd5,    16'h0000, 1'b1, NO_CLUSTER},
        // new first sample of 200, then a foreign-label element overwrites cluster 7
        '{OP_ACCUMULATE, 8'd200, 10'd0,    16'h8000, 1'b0, NO_CLUSTER},
        '{OP_ACCUMULATE, 8'd7,   10'd2,    16'h0001, 1'b0, NO_CLUSTER},
        '{OP_QUERY,      8'd7,   10'd2,    16'h0000, 1'b0, NO_CLUSTER},
        '{OP_ACCUMULATE, 8'd200, 10'd1023, 16'hFFFF, 1'b0, NO_CLUSTER},
        '{OP_QUERY,      8'd200, 10'd1023, 16'h0000, 1'b1, '{1'b1, 16'd1, 24'hFFFF00}},
        // later sample of 200, then repeated adds into cluster 7 push its mean past the cap
        '{OP_ACCUMULATE, 8'd200, 10'd0,    16'h0001, 1'b0, NO_CLUSTER},
        '{OP_ACCUMULATE, 8'd7,   10'd1,    16'hFFFF, 1'b0, NO_CLUSTER},
        '{OP_ACCUMULATE, 8'd7,   10'd1,    16'hFFFF, 1'b0, NO_CLUSTER},
        '{OP_QUERY,      8'd7,   10'd1,    16'h0000, 1'b1, '{1'b1, 16'd2, 24'hFFFFFF}},
        '{OP_QUERY,      8'd200, 10'd0,    16'h0000, 1'b0, NO_CLUSTER},
        // top label
        '{OP_ACCUMULATE, 8'd255, 10'd0,    16'hFFFF, 1'b0, NO_CLUSTER},
        '{OP_QUERY,      8'd255, 10'd0,    16'h0000, 1'b1, '{1'b1, 16'd1, 24'hFFFF00}}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    cluster_centroid_accumulator_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Predictor state: one sum per (label, index), a count and a seen flag per cluster,
    // and the flag saying the sample in flight is its cluster's first.
    logic [SUM_W-1:0]   centroid_sums [SUM_DEPTH];
    bit                 sum_written   [SUM_DEPTH];   // tracks entries that hold real data
    logic [COUNT_W-1:0] member_counts [NUM_CLUSTERS];
    bit                 cluster_seen  [NUM_CLUSTERS];
    bit                 first_sample;

    centroid_t pending_centroids [$];   // answers owed by the block, oldest first
    int        mismatches;
    int        counted_items;           // transfers that were not simply dropped
    bit        tx_idling;
    bit        rx_idling;
    bit        quiet_tail;              // no idling on either side near the end
    int        rx_stall_left;

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Applies one transfer to the predictor state; answers tells whether a result is owed.
    function automatic void apply_to_centroids(
        input  ccacc_op_t          op,
        input  logic [LABEL_W-1:0] label,
        input  logic [INDEX_W-1:0] idx,
        input  logic [SAMPLE_W-1:0] val,
        output bit                 answers,
        output bit                 counted,
        output centroid_t          answer
    );
        logic [SUM_AW-1:0]   pos;
        logic [SUM_W:0]      grown;
        logic [DIVIDEND_W-1:0] quotient;

        pos     = {label, idx};
        answers = 1'b0;
        counted = 1'b0;
        answer  = NO_CLUSTER;
        if (op == OP_ACCUMULATE) begin
            if (idx == '0) begin
                if (!cluster_seen[label]) begin
                    cluster_seen[label]  = 1'b1;
                    member_counts[label] = 16'd1;
                    first_sample         = 1'b1;
                end else begin
                    first_sample = 1'b0;
                    if (member_counts[label] != '1)
                        member_counts[label] = member_counts[label] + COUNT_W'(1);
                end
            end
            if (!cluster_seen[label])
                return;   // unseen cluster, no start: dropped
            counted = 1'b1;
            if (first_sample) begin
                centroid_sums[pos] = SUM_W'(val);
                sum_written[pos]   = 1'b1;
            end else begin
                grown = {1'b0, centroid_sums[pos]} + (SUM_W + 1)'(val);
                centroid_sums[pos] = grown[SUM_W] ? '1 : grown[SUM_W-1:0];
            end
            return;
        end
        answers = 1'b1;
        counted = 1'b1;
        if (!cluster_seen[label] || member_counts[label] == '0)
            return;
        quotient = {centroid_sums[pos], {FRAC_SHIFT{1'b0}}} /
                   DIVIDEND_W'(member_counts[label]);
        answer.valid = 1'b1;
        answer.count = member_counts[label];
        answer.mean  = (quotient > DIVIDEND_W'(24'hFFFFFF)) ? '1 : quotient[MEAN_W-1:0];
    endfunction

    // True where the transfer would add into or read a sum no sample ever wrote.
    function automatic bit hits_unwritten_sum(
        input ccacc_op_t          op,
        input logic [LABEL_W-1:0] label,
        input logic [INDEX_W-1:0] idx
    );
        logic [SUM_AW-1:0] pos;

        pos = {label, idx};
        if (!cluster_seen[label] || sum_written[pos])
            return 1'b0;
        if (op == OP_QUERY)
            return 1'b1;
        return (idx != '0) && !first_sample;
    endfunction

    // Predicts, then holds the transfer on s_ until it is taken. Ends on the accepting edge,
    // followed by an optional idle burst.
    task automatic send_item(
        input ccacc_op_t           op,
        input logic [LABEL_W-1:0]  label,
        input logic [INDEX_W-1:0]  idx,
        input logic [SAMPLE_W-1:0] val,
        input bit                  typed,
        input centroid_t           want
    );
        bit                   answers;
        bit                   counted;
        centroid_t            answer;
        logic [S_TDATA_W-1:0] word;

        apply_to_centroids(op, label, idx, val, answers, counted, answer);
        if (answers)
            pending_centroids = {pending_centroids, (typed ? want : answer)};
        if (counted)
            counted_items++;

        word = '0;
        word[S_LABEL_LSB +: LABEL_W]  = label;
        word[S_INDEX_LSB +: INDEX_W]  = idx;
        word[S_VALUE_LSB +: SAMPLE_W] = val;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);

        if (!quiet_tail && tx_idling && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        if ($urandom_range(0, 39) == 0)
            tx_idling = !tx_idling;
    endtask

    // Lower valid and let the block hand back everything it owes.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (pending_centroids.size() != 0);
    endtask

    // Result side: check on each accepting edge, then pick the next tready.
    always @(posedge aclk) begin
        centroid_t got;
        centroid_t want;

        if (aresetn && m_tvalid && m_tready) begin
            got.valid = m_tuser[0];
            got.count = m_tdata[COUNT_W-1:0];
            got.mean  = m_tdata[COUNT_W +: MEAN_W];
            if (pending_centroids.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result transfer: valid %0b count %0d mean %h",
                             $realtime, got.valid, got.count, got.mean);
            end else begin
                want = pending_centroids.pop_front();
                if (got.valid !== want.valid || got.count !== want.count ||
                    got.mean !== want.mean) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: result mismatch: exp valid %0b count %0d mean %h,",
                                  " got %0b %0d %h"},
                                 $realtime, want.valid, want.count, want.mean,
                                 got.valid, got.count, got.mean);
                end
            end
        end

        if (rx_stall_left > 0)
            rx_stall_left--;
        else if (!quiet_tail && rx_idling && $urandom_range(0, 9) == 0)
            rx_stall_left = $urandom_range(1, 17);
        if ($urandom_range(0, 255) == 0)
            rx_idling = !rx_idling;
        m_tready <= (rx_stall_left == 0);
    end

    // Hard stop in case the block hangs.
    initial begin
        #20_000_000;
        $display("tb_cluster_centroid_accumulator_top NOT OK");
        $finish;
    end

    initial begin
        logic [LABEL_W-1:0]  label_pool [8];
        logic [LABEL_W-1:0]  label;
        logic [INDEX_W-1:0]  idx;
        ccacc_op_t           op;
        int                  pick;
        int                  run_len;
        bit                  paused;

        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_ACCUMULATE;
        m_tready      = 1'b0;
        first_sample  = 1'b0;
        mismatches    = 0;
        counted_items = 0;
        tx_idling     = 1'b1;
        rx_idling     = 1'b1;
        quiet_tail    = 1'b0;
        rx_stall_left = 0;
        paused        = 1'b0;
        foreach (cluster_seen[i])
            cluster_seen[i] = 1'b0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: typed answers where obvious, the predictor elsewhere.
        foreach (DIRECTED[r])
            send_item(DIRECTED[r].op, DIRECTED[r].label, DIRECTED[r].idx, DIRECTED[r].val,
                      DIRECTED[r].typed, DIRECTED[r].want);
        drain_results();

        // Random part: mostly in-order samples of a few busy clusters, queries on them,
        // and some noise with arbitrary labels and indexes.
        foreach (label_pool[i])
            label_pool[i] = LABEL_W'($urandom_range(0, 255));
        counted_items = 0;
        while (counted_items < RANDOM_ITEMS) begin
            pick  = $urandom_range(0, 99);
            label = ($urandom_range(0, 3) == 0) ? LABEL_W'($urandom_range(0, 255))
                                                : label_pool[3'($urandom_range(0, 7))];
            if (pick < 55) begin
                run_len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 64)
                                                       : $urandom_range(1, 6);
                for (int e = 0; e < run_len; e++)
                    if (!hits_unwritten_sum(OP_ACCUMULATE, label, INDEX_W'(e)))
                        send_item(OP_ACCUMULATE, label, INDEX_W'(e),
                                  SAMPLE_W'($urandom_range(0, 65535)), 1'b0, NO_CLUSTER);
            end else if (pick < 85) begin
                idx = ($urandom_range(0, 3) == 0) ? INDEX_W'($urandom_range(0, 1023))
                                                  : INDEX_W'($urandom_range(0, 7));
                if (hits_unwritten_sum(OP_QUERY, label, idx))
                    idx = '0;   // index 0 of a seen cluster is always written
                send_item(OP_QUERY, label, idx, SAMPLE_W'($urandom_range(0, 65535)),
                          1'b0, NO_CLUSTER);
            end else begin
                op  = ccacc_op_t'($urandom_range(0, 1));
                idx = ($urandom_range(0, 2) == 0) ? '0 : INDEX_W'($urandom_range(0, 1023));
                if (!hits_unwritten_sum(op, label, idx))
                    send_item(op, label, idx, SAMPLE_W'($urandom_range(0, 65535)),
                              1'b0, NO_CLUSTER);
            end

            if (!paused && counted_items >= RANDOM_ITEMS / 2) begin
                drain_results();
                paused = 1'b1;
            end
            if (counted_items >= RANDOM_ITEMS - 80)
                quiet_tail = 1'b1;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("tb_cluster_centroid_accumulator_top OK");
        else
            $display("tb_cluster_centroid_accumulator_top NOT OK");
        $finish;
    end

endmodule
